/* rtl/core/bos_pkg.sv */
// Shared types, codes and constants of the bulk-only storage engine.
package bos_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 1024;
  localparam int unsigned SIZE_W           = $clog2(MAX_PACKET_BYTES + 1);

  localparam logic [SIZE_W-1:0] SIZE_MAX  = SIZE_W'(MAX_PACKET_BYTES);
  localparam logic [SIZE_W-1:0] CBW_BYTES = SIZE_W'(31);
  localparam logic [SIZE_W-1:0] CSW_BYTES = SIZE_W'(13);
  localparam logic [31:0]       CBW_SIG   = 32'h4342_5355;
  localparam logic [3:0]        EP_BULK_OUT = 4'd2;
  localparam logic [3:0]        EP_BULK_IN  = 4'd1;
  localparam int unsigned       FLAG_DIR_IN = 7;

  typedef enum logic [2:0] {
    OP_BULK_OUT,
    OP_BULK_IN,
    OP_SCSI_READY,
    OP_SCSI_DONE,
    OP_SCSI_CANCEL,
    OP_BUS_RESET,
    OP_CONTROL,
    OP_HOST_CANCEL
  } bos_op_t;

  typedef enum logic [1:0] {
    PH_CMD,
    PH_OUT,
    PH_IN,
    PH_STS
  } bos_phase_t;

  typedef enum logic [1:0] {
    PS_NONE,
    PS_OK,
    PS_STALL,
    PS_DEFER
  } bos_pstat_t;

  typedef enum logic [1:0] {
    REQ_CLEAR_FEATURE,
    REQ_MS_RESET,
    REQ_GET_MAX_LUN,
    REQ_OTHER
  } bos_req_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [3:0]        endpoint;
    logic [SIZE_W-1:0] packet_size;
    logic [31:0]       cbw_signature;
    logic [31:0]       cbw_tag;
    logic [31:0]       cbw_data_len;
    logic [7:0]        cbw_flags;
    logic [7:0]        cbw_lun;
    logic [31:0]       transfer_len;
    logic [7:0]        scsi_status;
    logic [1:0]        request_code;
    logic              enqueue_nonzero;
  } bos_item_t;

  typedef struct packed {
    logic [1:0]        packet_status;
    logic [SIZE_W-1:0] bytes_copied;
    logic [SIZE_W-1:0] bytes_skipped;
    logic              parked_completed;
    logic              status_sent;
    logic [31:0]       csw_tag;
    logic [31:0]       csw_residue;
    logic              csw_failed;
    logic              scsi_start;
    logic              scsi_continue;
    logic [3:0]        max_lun_reply;
    logic [1:0]        phase;
  } bos_result_t;

endpackage

/* rtl/core/bos_if.sv */
// Valid/ready channel interfaces for event beats and result beats.
interface bos_item_if;
  import bos_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic [3:0]        endpoint;
  logic [SIZE_W-1:0] packet_size;
  logic [31:0]       cbw_signature;
  logic [31:0]       cbw_tag;
  logic [31:0]       cbw_data_len;
  logic [7:0]        cbw_flags;
  logic [7:0]        cbw_lun;
  logic [31:0]       transfer_len;
  logic [7:0]        scsi_status;
  logic [1:0]        request_code;
  logic              enqueue_nonzero;

  modport source (
    output valid, opcode, endpoint, packet_size, cbw_signature, cbw_tag, cbw_data_len,
           cbw_flags, cbw_lun, transfer_len, scsi_status, request_code, enqueue_nonzero,
    input  ready
  );
  modport sink (
    input  valid, opcode, endpoint, packet_size, cbw_signature, cbw_tag, cbw_data_len,
           cbw_flags, cbw_lun, transfer_len, scsi_status, request_code, enqueue_nonzero,
    output ready
  );
endinterface

interface bos_result_if;
  import bos_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        packet_status;
  logic [SIZE_W-1:0] bytes_copied;
  logic [SIZE_W-1:0] bytes_skipped;
  logic              parked_completed;
  logic              status_sent;
  logic [31:0]       csw_tag;
  logic [31:0]       csw_residue;
  logic              csw_failed;
  logic              scsi_start;
  logic              scsi_continue;
  logic [3:0]        max_lun_reply;
  logic [1:0]        phase;

  modport source (
    output valid, packet_status, bytes_copied, bytes_skipped, parked_completed,
           status_sent, csw_tag, csw_residue, csw_failed, scsi_start, scsi_continue,
           max_lun_reply, phase,
    input  ready
  );
  modport sink (
    input  valid, packet_status, bytes_copied, bytes_skipped, parked_completed,
           status_sent, csw_tag, csw_residue, csw_failed, scsi_start, scsi_continue,
           max_lun_reply, phase,
    output ready
  );
endinterface

/* rtl/core/bos_engine.sv */
// Transport state registers and the single-pass event step logic.
module bos_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_data,
  input  logic                step,
  input  bos_pkg::bos_item_t  item,
  output bos_pkg::bos_result_t res
);
  import bos_pkg::*;

  logic [3:0]        highest_lun;
  bos_phase_t        bot_phase, bot_phase_next;
  logic [31:0]       data_remaining, data_remaining_next;
  logic [31:0]       scsi_remaining, scsi_remaining_next;
  logic [31:0]       status_tag, status_tag_next;
  logic [31:0]       status_residue, status_residue_next;
  logic              status_failed, status_failed_next;
  logic              command_in_flight, command_in_flight_next;
  logic              packet_parked, packet_parked_next;
  logic [SIZE_W-1:0] parked_size, parked_size_next;
  logic [SIZE_W-1:0] parked_done, parked_done_next;

  bos_op_t           op;
  bos_req_t          req;
  logic [SIZE_W-1:0] sz;
  logic              ep_out_ok, ep_in_ok, cbw_ok, fits, csw_fits, xfer, send_cond;
  logic              scsi_fail;

  logic              mv_parked;
  logic [SIZE_W-1:0] mv_size, mv_done, mv_room, mv_n, mv_done_n;
  logic [31:0]       mv_srem, mv_srem_n, mv_drem_n;
  logic              mv_cont, mv_full;

  logic              do_mv, do_sk, blk_park;
  logic [SIZE_W-1:0] b_done;
  logic [31:0]       b_drem, blk_drem;

  logic              sk_parked;
  logic [SIZE_W-1:0] sk_size, sk_done, sk_n;
  logic [31:0]       sk_drem, sk_drem_n;
  logic              sk_to_sts;

  assign op        = bos_op_t'(item.opcode);
  assign req       = bos_req_t'(item.request_code);
  assign sz        = (item.packet_size > SIZE_MAX) ? SIZE_MAX : item.packet_size;
  assign ep_out_ok = (item.endpoint == EP_BULK_OUT);
  assign ep_in_ok  = (item.endpoint == EP_BULK_IN);
  assign cbw_ok    = (sz == CBW_BYTES) && (item.cbw_signature == CBW_SIG) &&
                     (item.cbw_lun <= {4'b0, highest_lun});
  assign fits      = !(32'(sz) > data_remaining);
  assign csw_fits  = !(sz < CSW_BYTES);
  assign scsi_fail = (item.scsi_status != 8'd0);
  assign send_cond = ((data_remaining == 32'd0) && (bot_phase == PH_OUT)) ||
                     (bot_phase == PH_STS);
  assign xfer      = ((op == OP_BULK_OUT) && ep_out_ok && (bot_phase == PH_OUT) && fits) ||
                     ((op == OP_BULK_IN) && ep_in_ok && (bot_phase == PH_IN));

  // copy unit: bulk packet against held data, or parked packet against fresh data
  assign mv_parked = (op == OP_SCSI_READY);
  assign mv_size   = mv_parked ? parked_size : sz;
  assign mv_done   = mv_parked ? parked_done : '0;
  assign mv_srem   = mv_parked ? item.transfer_len : scsi_remaining;
  assign mv_room   = mv_size - mv_done;
  assign mv_n      = (32'(mv_room) > mv_srem) ? mv_srem[SIZE_W-1:0] : mv_room;
  assign mv_done_n = mv_done + mv_n;
  assign mv_srem_n = mv_srem - 32'(mv_n);
  assign mv_drem_n = (32'(mv_n) > data_remaining) ? 32'd0 : data_remaining - 32'(mv_n);
  assign mv_cont   = (mv_srem_n == 32'd0) || (mv_drem_n == 32'd0);
  assign mv_full   = (mv_done_n == parked_size);

  assign do_mv  = (scsi_remaining != 32'd0);
  assign do_sk  = (status_residue != 32'd0);
  assign b_done = do_mv ? mv_done_n : '0;
  assign b_drem = do_mv ? mv_drem_n : data_remaining;

  // skip unit: rest of a bulk packet, or rest of the parked packet at completion
  assign sk_parked = (op == OP_SCSI_DONE);
  assign sk_size   = sk_parked ? parked_size : sz;
  assign sk_done   = sk_parked ? parked_done : b_done;
  assign sk_drem   = sk_parked ? data_remaining : b_drem;
  assign sk_n      = sk_size - sk_done;
  assign sk_drem_n = (32'(sk_n) > sk_drem) ? 32'd0 : sk_drem - 32'(sk_n);
  assign sk_to_sts = (sk_n != '0) && (sk_drem_n == 32'd0);

  assign blk_park = !do_sk && (b_done != sz);
  assign blk_drem = do_sk ? sk_drem_n : b_drem;

  always_comb begin
    bot_phase_next         = bot_phase;
    data_remaining_next    = data_remaining;
    scsi_remaining_next    = scsi_remaining;
    status_tag_next        = status_tag;
    status_residue_next    = status_residue;
    status_failed_next     = status_failed;
    command_in_flight_next = command_in_flight;
    packet_parked_next     = packet_parked;
    parked_size_next       = parked_size;
    parked_done_next       = parked_done;
    case (op)
      OP_BULK_OUT: begin
        if (ep_out_ok && (bot_phase == PH_CMD) && cbw_ok) begin
          status_tag_next        = item.cbw_tag;
          data_remaining_next    = item.cbw_data_len;
          scsi_remaining_next    = 32'd0;
          command_in_flight_next = 1'b1;
          if (item.cbw_data_len == 32'd0) begin
            bot_phase_next = PH_STS;
          end else if (item.cbw_flags[FLAG_DIR_IN]) begin
            bot_phase_next = PH_IN;
          end else begin
            bot_phase_next = PH_OUT;
          end
        end
      end
      OP_BULK_IN: begin
        if (ep_in_ok && csw_fits) begin
          if ((bot_phase == PH_OUT) && (data_remaining == 32'd0)) begin
            packet_parked_next = 1'b1;
            parked_size_next   = sz;
            parked_done_next   = '0;
          end else if (bot_phase == PH_STS) begin
            if (command_in_flight) begin
              packet_parked_next = 1'b1;
              parked_size_next   = sz;
              parked_done_next   = '0;
            end else begin
              status_tag_next     = 32'd0;
              status_residue_next = 32'd0;
              status_failed_next  = 1'b0;
              bot_phase_next      = PH_CMD;
            end
          end
        end
      end
      OP_SCSI_READY: begin
        if (command_in_flight) begin
          scsi_remaining_next = item.transfer_len;
          if (packet_parked) begin
            scsi_remaining_next = mv_srem_n;
            data_remaining_next = mv_drem_n;
            parked_done_next    = mv_done_n;
            if (mv_full) begin
              packet_parked_next = 1'b0;
            end
          end
        end
      end
      OP_SCSI_DONE: begin
        if (command_in_flight) begin
          command_in_flight_next = 1'b0;
          status_residue_next    = data_remaining;
          status_failed_next     = scsi_fail;
          if (packet_parked) begin
            packet_parked_next = 1'b0;
            if (send_cond) begin
              status_tag_next     = 32'd0;
              status_residue_next = 32'd0;
              status_failed_next  = 1'b0;
              bot_phase_next      = PH_CMD;
            end else begin
              data_remaining_next = sk_drem_n;
              if (sk_drem_n == 32'd0) begin
                bot_phase_next = PH_STS;
              end
            end
          end else if (data_remaining == 32'd0) begin
            bot_phase_next = PH_STS;
          end
        end
      end
      OP_SCSI_CANCEL: begin
        if (command_in_flight) begin
          status_failed_next     = 1'b1;
          command_in_flight_next = 1'b0;
          scsi_remaining_next    = 32'd0;
        end
      end
      OP_BUS_RESET: begin
        if (command_in_flight) begin
          command_in_flight_next = 1'b0;
          scsi_remaining_next    = 32'd0;
        end
        packet_parked_next  = 1'b0;
        status_tag_next     = 32'd0;
        status_residue_next = 32'd0;
        status_failed_next  = 1'b0;
        bot_phase_next      = PH_CMD;
      end
      OP_CONTROL: begin
        if (req == REQ_MS_RESET) begin
          bot_phase_next = PH_CMD;
        end
      end
      OP_HOST_CANCEL: begin
        packet_parked_next = 1'b0;
        if (command_in_flight) begin
          status_failed_next     = 1'b1;
          command_in_flight_next = 1'b0;
          scsi_remaining_next    = 32'd0;
        end
      end
      default: begin
      end
    endcase
    if (xfer) begin
      data_remaining_next = blk_drem;
      if (do_mv) begin
        scsi_remaining_next = mv_srem_n;
      end
      if (do_sk && sk_to_sts) begin
        bot_phase_next = PH_STS;
      end
      if (blk_park) begin
        packet_parked_next = 1'b1;
        parked_size_next   = sz;
        parked_done_next   = b_done;
      end
    end
  end

  always_comb begin
    res       = '0;
    res.phase = bot_phase_next;
    case (op)
      OP_BULK_OUT: begin
        if (ep_out_ok && (bot_phase == PH_CMD) && cbw_ok) begin
          res.scsi_start    = 1'b1;
          res.scsi_continue = item.enqueue_nonzero;
          res.packet_status = PS_OK;
        end else if (!xfer) begin
          res.packet_status = PS_STALL;
        end
      end
      OP_BULK_IN: begin
        if (!ep_in_ok || !csw_fits) begin
          if (!xfer) begin
            res.packet_status = PS_STALL;
          end
        end else begin
          case (bot_phase)
            PH_OUT: begin
              res.packet_status = (data_remaining != 32'd0) ? PS_STALL : PS_DEFER;
            end
            PH_STS: begin
              if (command_in_flight) begin
                res.packet_status = PS_DEFER;
              end else begin
                res.status_sent   = 1'b1;
                res.csw_tag       = status_tag;
                res.csw_residue   = status_residue;
                res.csw_failed    = status_failed;
                res.packet_status = PS_OK;
              end
            end
            PH_IN: begin
            end
            default: begin
              res.packet_status = PS_STALL;
            end
          endcase
        end
      end
      OP_SCSI_READY: begin
        if (command_in_flight && packet_parked) begin
          res.bytes_copied  = mv_n;
          res.scsi_continue = mv_cont;
          if (mv_full) begin
            res.parked_completed = 1'b1;
            res.packet_status    = PS_OK;
          end
        end
      end
      OP_SCSI_DONE: begin
        if (command_in_flight && packet_parked) begin
          res.parked_completed = 1'b1;
          res.packet_status    = PS_OK;
          if (send_cond) begin
            res.status_sent = 1'b1;
            res.csw_tag     = status_tag;
            res.csw_residue = data_remaining;
            res.csw_failed  = scsi_fail;
          end else if (data_remaining != 32'd0) begin
            res.bytes_skipped = sk_n;
          end
        end
      end
      OP_BUS_RESET: begin
        if (packet_parked) begin
          res.parked_completed = 1'b1;
          res.packet_status    = PS_STALL;
        end
      end
      OP_CONTROL: begin
        case (req)
          REQ_CLEAR_FEATURE: res.packet_status = PS_OK;
          REQ_MS_RESET:      res.packet_status = PS_OK;
          REQ_GET_MAX_LUN: begin
            res.max_lun_reply = highest_lun;
            res.packet_status = PS_OK;
          end
          default:           res.packet_status = PS_STALL;
        endcase
      end
      default: begin
      end
    endcase
    if (xfer) begin
      res.bytes_copied  = do_mv ? mv_n : '0;
      res.bytes_skipped = do_sk ? sk_n : '0;
      res.scsi_continue = do_mv && mv_cont;
      res.packet_status = blk_park ? PS_DEFER : PS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      highest_lun <= 4'd0;
    end else if (cfg_we) begin
      highest_lun <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bot_phase         <= PH_CMD;
      data_remaining    <= 32'd0;
      scsi_remaining    <= 32'd0;
      status_tag        <= 32'd0;
      status_residue    <= 32'd0;
      status_failed     <= 1'b0;
      command_in_flight <= 1'b0;
      packet_parked     <= 1'b0;
      parked_size       <= '0;
      parked_done       <= '0;
    end else if (step) begin
      bot_phase         <= bot_phase_next;
      data_remaining    <= data_remaining_next;
      scsi_remaining    <= scsi_remaining_next;
      status_tag        <= status_tag_next;
      status_residue    <= status_residue_next;
      status_failed     <= status_failed_next;
      command_in_flight <= command_in_flight_next;
      packet_parked     <= packet_parked_next;
      parked_size       <= parked_size_next;
      parked_done       <= parked_done_next;
    end
  end

  a_parked_partial: assert property (@(posedge clk) disable iff (rst)
    packet_parked |-> (parked_done < parked_size))
    else $error("parked packet already full");

  a_sent_to_cmd: assert property (@(posedge clk) disable iff (rst)
    (step && res.status_sent) |-> (res.phase == PH_CMD))
    else $error("status sent without return to command phase");

  a_start_in_flight: assert property (@(posedge clk) disable iff (rst)
    (step && res.scsi_start) |=> command_in_flight)
    else $error("command start did not mark command in flight");

  a_bus_reset_clears: assert property (@(posedge clk) disable iff (rst)
    (step && (op == OP_BUS_RESET)) |=> ((bot_phase == PH_CMD) && !packet_parked))
    else $error("bus reset left phase or parked packet");

endmodule

/* rtl/core/usb_bulk_only_storage_engine.sv */
// Top level of the bulk-only storage engine: event register, step logic, result register.
//
// Channels: item carries one event beat (bulk packet, scsi event, bus reset,
// control request or host cancel); result returns exactly one beat per event,
// in order. Both use valid/ready; a beat moves when both are high.
// cfg_we/cfg_data write highest_lun; write it only while the block is idle.
//
// Path: an event waits in the event register until the result register is
// empty or being taken; the step logic then loads the result register.
// Throughput: one event per cycle while the receiver takes results; the
// step logic reads and updates the transport state for each event, so
// back-to-back events see each other.
//
// Reset (rst, synchronous): command phase, all counts and status fields zero,
// no parked packet, highest_lun zero, both registers empty.
// Receiver stall: the result register holds its beat; the event register still
// takes one more beat, then item.ready drops until result.ready returns.
module usb_bulk_only_storage_engine (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_data,
  bos_item_if.sink     item,
  bos_result_if.source result
);
  import bos_pkg::*;

  logic        q_valid;
  bos_item_t   q;
  logic        r_valid;
  bos_result_t r;
  bos_result_t res;
  logic        advance;

  assign advance    = q_valid && (!r_valid || result.ready);
  assign item.ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (item.ready) begin
      q_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      q.opcode          <= item.opcode;
      q.endpoint        <= item.endpoint;
      q.packet_size     <= item.packet_size;
      q.cbw_signature   <= item.cbw_signature;
      q.cbw_tag         <= item.cbw_tag;
      q.cbw_data_len    <= item.cbw_data_len;
      q.cbw_flags       <= item.cbw_flags;
      q.cbw_lun         <= item.cbw_lun;
      q.transfer_len    <= item.transfer_len;
      q.scsi_status     <= item.scsi_status;
      q.request_code    <= item.request_code;
      q.enqueue_nonzero <= item.enqueue_nonzero;
    end
  end

  bos_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .step     (advance),
    .item     (q),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (advance) begin
      r_valid <= 1'b1;
    end else if (result.ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      r <= res;
    end
  end

  assign result.valid            = r_valid;
  assign result.packet_status    = r.packet_status;
  assign result.bytes_copied     = r.bytes_copied;
  assign result.bytes_skipped    = r.bytes_skipped;
  assign result.parked_completed = r.parked_completed;
  assign result.status_sent      = r.status_sent;
  assign result.csw_tag          = r.csw_tag;
  assign result.csw_residue      = r.csw_residue;
  assign result.csw_failed       = r.csw_failed;
  assign result.scsi_start       = r.scsi_start;
  assign result.scsi_continue    = r.scsi_continue;
  assign result.max_lun_reply    = r.max_lun_reply;
  assign result.phase            = r.phase;

endmodule

/* verif/usb_bulk_only_storage_engine_test.sv */
// Self-checking testbench: scripted and random bulk-only transport events, checked beat by beat.
module usb_bulk_only_storage_engine_test;
  import bos_pkg::*;

  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned EVENTS_PER_LUN = 100;

  typedef struct {
    bos_item_t   ev;
    bit          typed;
    bos_result_t want;
  } script_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [3:0] cfg_data;

  bos_item_if   item_ch ();
  bos_result_if result_ch ();

  usb_bulk_only_storage_engine dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (item_ch),
    .result   (result_ch)
  );

  bos_phase_t        ph;
  logic [31:0]       host_left;
  logic [31:0]       scsi_left;
  logic [31:0]       csw_tag_q;
  logic [31:0]       csw_res_q;
  logic              csw_fail_q;
  logic              in_flight;
  logic              parked;
  logic [SIZE_W-1:0] park_size;
  logic [SIZE_W-1:0] park_done;
  logic [3:0]        max_lun;

  bos_result_t expected_beats[$];
  script_row_t script[$];
  bos_result_t seen;
  bos_result_t oldest;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  bit          gaps_on;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void copy_from_scsi(input logic [SIZE_W-1:0] size,
                                         inout logic [SIZE_W-1:0] done,
                                         inout bos_result_t r);
    logic [SIZE_W-1:0] n;
    n = size - done;
    if (n > scsi_left) n = scsi_left[SIZE_W-1:0];
    done += n;
    scsi_left -= 32'(n);
    r.bytes_copied = n;
    if (n > host_left) n = host_left[SIZE_W-1:0];
    host_left -= 32'(n);
    if (scsi_left == 0 || host_left == 0) r.scsi_continue = 1'b1;
  endfunction

  function automatic void skip_packet_rest(input logic [SIZE_W-1:0] size,
                                           inout logic [SIZE_W-1:0] done,
                                           inout bos_result_t r);
    logic [SIZE_W-1:0] n;
    n = size - done;
    if (n != 0) begin
      done += n;
      r.bytes_skipped = n;
      if (n > host_left) n = host_left[SIZE_W-1:0];
      host_left -= 32'(n);
      if (host_left == 0) ph = PH_STS;
    end
  endfunction

  function automatic void send_csw(inout bos_result_t r);
    r.status_sent = 1'b1;
    r.csw_tag     = csw_tag_q;
    r.csw_residue = csw_res_q;
    r.csw_failed  = csw_fail_q;
    csw_tag_q  = '0;
    csw_res_q  = '0;
    csw_fail_q = 1'b0;
  endfunction

  function automatic void drop_command();
    if (in_flight) begin
      csw_fail_q = 1'b1;
      in_flight  = 1'b0;
      scsi_left  = '0;
    end
  endfunction

  function automatic void park_packet(input logic [SIZE_W-1:0] size,
                                      input logic [SIZE_W-1:0] done,
                                      inout bos_result_t r);
    parked    = 1'b1;
    park_size = size;
    park_done = done;
    r.packet_status = PS_DEFER;
  endfunction

  function automatic bos_result_t step_transport(input bos_item_t ev);
    bos_result_t       r;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] done;
    r    = '0;
    done = '0;
    size = (ev.packet_size > SIZE_MAX) ? SIZE_MAX : ev.packet_size;
    case (bos_op_t'(ev.opcode))
      OP_BULK_OUT: begin
        if (ev.endpoint != EP_BULK_OUT) begin
          r.packet_status = PS_STALL;
        end else if (ph == PH_CMD) begin
          if (size != CBW_BYTES || ev.cbw_signature != CBW_SIG || ev.cbw_lun > 8'(max_lun)) begin
            r.packet_status = PS_STALL;
          end else begin
            csw_tag_q = ev.cbw_tag;
            host_left = ev.cbw_data_len;
            if (ev.cbw_data_len == 0) ph = PH_STS;
            else if (ev.cbw_flags[FLAG_DIR_IN]) ph = PH_IN;
            else ph = PH_OUT;
            scsi_left       = '0;
            in_flight       = 1'b1;
            r.scsi_start    = 1'b1;
            r.scsi_continue = ev.enqueue_nonzero;
            r.packet_status = PS_OK;
          end
        end else if (ph == PH_OUT) begin
          if (size > host_left) begin
            r.packet_status = PS_STALL;
          end else begin
            if (scsi_left != 0) copy_from_scsi(size, done, r);
            if (csw_res_q != 0) skip_packet_rest(size, done, r);
            if (done < size) park_packet(size, done, r);
            else r.packet_status = PS_OK;
          end
        end else begin
          r.packet_status = PS_STALL;
        end
      end
      OP_BULK_IN: begin
        if (ev.endpoint != EP_BULK_IN) begin
          r.packet_status = PS_STALL;
        end else if (ph == PH_OUT) begin
          if (host_left != 0 || size < CSW_BYTES) r.packet_status = PS_STALL;
          else park_packet(size, '0, r);
        end else if (ph == PH_STS) begin
          if (size < CSW_BYTES) begin
            r.packet_status = PS_STALL;
          end else if (in_flight) begin
            park_packet(size, '0, r);
          end else begin
            send_csw(r);
            ph = PH_CMD;
            r.packet_status = PS_OK;
          end
        end else if (ph == PH_IN) begin
          if (scsi_left != 0) copy_from_scsi(size, done, r);
          if (csw_res_q != 0) skip_packet_rest(size, done, r);
          if (done < size && ph == PH_IN) park_packet(size, done, r);
          else r.packet_status = PS_OK;
        end else begin
          r.packet_status = PS_STALL;
        end
      end
      OP_SCSI_READY: begin
        if (in_flight) begin
          scsi_left = ev.transfer_len;
          if (parked) begin
            copy_from_scsi(park_size, park_done, r);
            if (park_done == park_size) begin
              parked = 1'b0;
              r.parked_completed = 1'b1;
              r.packet_status    = PS_OK;
            end
          end
        end
      end
      OP_SCSI_DONE: begin
        if (in_flight) begin
          csw_res_q  = host_left;
          csw_fail_q = (ev.scsi_status != 0);
          if (parked) begin
            if ((host_left == 0 && ph == PH_OUT) || ph == PH_STS) begin
              send_csw(r);
              ph = PH_CMD;
            end else begin
              if (host_left != 0) skip_packet_rest(park_size, park_done, r);
              if (host_left == 0) ph = PH_STS;
            end
            parked = 1'b0;
            r.parked_completed = 1'b1;
            r.packet_status    = PS_OK;
          end else if (host_left == 0) begin
            ph = PH_STS;
          end
          in_flight = 1'b0;
        end
      end
      OP_SCSI_CANCEL: drop_command();
      OP_BUS_RESET: begin
        drop_command();
        if (parked) begin
          parked = 1'b0;
          r.parked_completed = 1'b1;
          r.packet_status    = PS_STALL;
        end
        csw_tag_q  = '0;
        csw_res_q  = '0;
        csw_fail_q = 1'b0;
        ph = PH_CMD;
      end
      OP_CONTROL: begin
        case (bos_req_t'(ev.request_code))
          REQ_CLEAR_FEATURE: r.packet_status = PS_OK;
          REQ_MS_RESET: begin
            ph = PH_CMD;
            r.packet_status = PS_OK;
          end
          REQ_GET_MAX_LUN: begin
            r.max_lun_reply = max_lun;
            r.packet_status = PS_OK;
          end
          default: r.packet_status = PS_STALL;
        endcase
      end
      default: begin
        parked = 1'b0;
        drop_command();
      end
    endcase
    r.phase = ph;
    return r;
  endfunction

  function automatic bos_item_t event_of(bos_op_t op, logic [3:0] ep, logic [SIZE_W-1:0] size);
    bos_item_t ev;
    ev = '0;
    ev.opcode      = op;
    ev.endpoint    = ep;
    ev.packet_size = size;
    return ev;
  endfunction

  function automatic bos_item_t wrapper_of(logic [31:0] tag, logic [31:0] dlen,
                                           logic [7:0] flags, logic [7:0] lun, logic enq);
    bos_item_t ev;
    ev = event_of(OP_BULK_OUT, EP_BULK_OUT, CBW_BYTES);
    ev.cbw_signature   = CBW_SIG;
    ev.cbw_tag         = tag;
    ev.cbw_data_len    = dlen;
    ev.cbw_flags       = flags;
    ev.cbw_lun         = lun;
    ev.enqueue_nonzero = enq;
    return ev;
  endfunction

  function automatic bos_result_t reply_of(bos_pstat_t ps, bos_phase_t phase_after);
    bos_result_t r;
    r = '0;
    r.packet_status = ps;
    r.phase         = phase_after;
    return r;
  endfunction

  // Bias toward well-formed transfers for the current phase, with some noise.
  function automatic bos_item_t random_event();
    bos_item_t   ev;
    int unsigned roll;
    int unsigned cap;
    ev.opcode          = 3'($urandom_range(0, 7));
    ev.endpoint        = 4'($urandom_range(0, 15));
    ev.packet_size     = SIZE_W'($urandom_range(0, 2047));
    ev.cbw_signature   = $urandom;
    ev.cbw_tag         = $urandom;
    ev.cbw_data_len    = $urandom;
    ev.cbw_flags       = 8'($urandom_range(0, 255));
    ev.cbw_lun         = 8'($urandom_range(0, 255));
    ev.transfer_len    = $urandom;
    ev.scsi_status     = 8'($urandom_range(0, 255));
    ev.request_code    = 2'($urandom_range(0, 3));
    ev.enqueue_nonzero = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (roll < 6) return ev;
    if (roll < 12) begin
      case ($urandom_range(0, 3))
        0: ev.opcode = OP_CONTROL;
        1: ev.opcode = OP_BUS_RESET;
        2: ev.opcode = OP_HOST_CANCEL;
        default: ev.opcode = OP_SCSI_CANCEL;
      endcase
      return ev;
    end
    if ($urandom_range(0, 3) != 0) ev.scsi_status = '0;
    if (ph == PH_CMD) begin
      ev.opcode        = OP_BULK_OUT;
      ev.endpoint      = EP_BULK_OUT;
      ev.packet_size   = CBW_BYTES;
      ev.cbw_signature = CBW_SIG;
      if ($urandom_range(0, 7) != 0) ev.cbw_lun = 8'($urandom_range(0, max_lun));
      case ($urandom_range(0, 9))
        0: ev.cbw_data_len = '0;
        1: ev.cbw_data_len = $urandom;
        default: ev.cbw_data_len = $urandom_range(1, 3000);
      endcase
      return ev;
    end
    roll = $urandom_range(0, 99);
    if (in_flight && roll < 25) begin
      ev.opcode = OP_SCSI_READY;
      if ($urandom_range(0, 7) != 0) ev.transfer_len = $urandom_range(0, 2500);
    end else if (in_flight && roll < 38) begin
      ev.opcode = OP_SCSI_DONE;
    end else if (ph == PH_OUT && host_left != 0) begin
      ev.opcode   = OP_BULK_OUT;
      ev.endpoint = EP_BULK_OUT;
      cap = (host_left < 32'd1024) ? host_left : 1024;
      if ($urandom_range(0, 3) != 0 && cap > 64) cap = 64;
      ev.packet_size = SIZE_W'($urandom_range(1, cap));
    end else if (ph == PH_IN) begin
      ev.opcode   = OP_BULK_IN;
      ev.endpoint = EP_BULK_IN;
      ev.packet_size = SIZE_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024)
                                                            : $urandom_range(1, 64));
    end else begin
      ev.opcode      = OP_BULK_IN;
      ev.endpoint    = EP_BULK_IN;
      ev.packet_size = SIZE_W'($urandom_range(13, 64));
    end
    return ev;
  endfunction

  task automatic hold_events(int unsigned cycles);
    @(negedge clk);
    item_ch.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_lun(logic [3:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we  <= 1'b0;
    max_lun = value;
  endtask

  task automatic send_event(bos_item_t ev, bit typed, bos_result_t want);
    bos_result_t predicted;
    if (gaps_on && $urandom_range(0, 5) == 0) hold_events($urandom_range(1, 11));
    @(negedge clk);
    item_ch.valid <= 1'b1;
    {item_ch.opcode, item_ch.endpoint, item_ch.packet_size, item_ch.cbw_signature,
     item_ch.cbw_tag, item_ch.cbw_data_len, item_ch.cbw_flags, item_ch.cbw_lun,
     item_ch.transfer_len, item_ch.scsi_status, item_ch.request_code,
     item_ch.enqueue_nonzero} <= ev;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predicted = step_transport(ev);
    expected_beats.push_back(typed ? want : predicted);
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(0, 10);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready) begin
      seen = {result_ch.packet_status, result_ch.bytes_copied, result_ch.bytes_skipped,
              result_ch.parked_completed, result_ch.status_sent, result_ch.csw_tag,
              result_ch.csw_residue, result_ch.csw_failed, result_ch.scsi_start,
              result_ch.scsi_continue, result_ch.max_lun_reply, result_ch.phase};
      if (expected_beats.size() == 0) begin
        $error("result beat with no event outstanding");
        mismatches++;
      end else begin
        oldest = expected_beats.pop_front();
        check_field("packet_status", oldest.packet_status, seen.packet_status);
        check_field("bytes_copied", oldest.bytes_copied, seen.bytes_copied);
        check_field("bytes_skipped", oldest.bytes_skipped, seen.bytes_skipped);
        check_field("parked_completed", oldest.parked_completed, seen.parked_completed);
        check_field("status_sent", oldest.status_sent, seen.status_sent);
        check_field("csw_tag", oldest.csw_tag, seen.csw_tag);
        check_field("csw_residue", oldest.csw_residue, seen.csw_residue);
        check_field("csw_failed", oldest.csw_failed, seen.csw_failed);
        check_field("scsi_start", oldest.scsi_start, seen.scsi_start);
        check_field("scsi_continue", oldest.scsi_continue, seen.scsi_continue);
        check_field("max_lun_reply", oldest.max_lun_reply, seen.max_lun_reply);
        check_field("phase", oldest.phase, seen.phase);
      end
    end
  end

  always @(posedge clk) begin
    if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
        (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("usb_bulk_only_storage_engine_test: errors");
        $finish;
      end
    end
  end

  initial begin
    bos_item_t   ev;
    bos_result_t want;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    item_ch.valid   = 1'b0;
    {item_ch.opcode, item_ch.endpoint, item_ch.packet_size, item_ch.cbw_signature,
     item_ch.cbw_tag, item_ch.cbw_data_len, item_ch.cbw_flags, item_ch.cbw_lun,
     item_ch.transfer_len, item_ch.scsi_status, item_ch.request_code,
     item_ch.enqueue_nonzero} = '0;
    gaps_on      = 1'b1;
    ph         = PH_CMD;
    host_left  = '0;
    scsi_left  = '0;
    csw_tag_q  = '0;
    csw_res_q  = '0;
    csw_fail_q = 1'b0;
    in_flight  = 1'b0;
    parked     = 1'b0;
    park_size  = '0;
    park_done  = '0;
    max_lun    = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_lun(4'd2);

    ev = event_of(OP_CONTROL, 4'd0, '0);
    ev.request_code = REQ_GET_MAX_LUN;
    want = reply_of(PS_OK, PH_CMD);
    want.max_lun_reply = 4'd2;
    script.push_back('{ev, 1'b1, want});
    ev.request_code = REQ_OTHER;
    script.push_back('{ev, 1'b1, reply_of(PS_STALL, PH_CMD)});
    ev.request_code = REQ_CLEAR_FEATURE;
    script.push_back('{ev, 1'b1, reply_of(PS_OK, PH_CMD)});
    script.push_back('{event_of(OP_BULK_IN, EP_BULK_IN, CSW_BYTES), 1'b1,
                       reply_of(PS_STALL, PH_CMD)});
    ev = wrapper_of(32'h1234_5678, 32'd64, 8'h00, 8'd0, 1'b0);
    ev.endpoint = 4'd15;
    script.push_back('{ev, 1'b1, reply_of(PS_STALL, PH_CMD)});
    ev = wrapper_of(32'h1234_5678, 32'd64, 8'h00, 8'd0, 1'b0);
    ev.packet_size = CBW_BYTES - 1;
    script.push_back('{ev, 1'b1, reply_of(PS_STALL, PH_CMD)});
    ev = wrapper_of(32'h1234_5678, 32'd64, 8'h00, 8'd0, 1'b0);
    ev.cbw_signature = 32'h5342_5355;
    script.push_back('{ev, 1'b1, reply_of(PS_STALL, PH_CMD)});
    script.push_back('{wrapper_of(32'h1234_5678, 32'd64, 8'h00, 8'd3, 1'b0), 1'b1,
                       reply_of(PS_STALL, PH_CMD)});
    ev = event_of(OP_SCSI_READY, 4'd0, '0);
    ev.transfer_len = 32'd512;
    script.push_back('{ev, 1'b1, reply_of(PS_NONE, PH_CMD)});
    script.push_back('{wrapper_of(32'hFFFF_FFFF, 32'd512, 8'h80, 8'd2, 1'b1), 1'b0, '0});
    script.push_back('{event_of(OP_BULK_IN, EP_BULK_IN, SIZE_W'(2047)), 1'b0, '0});
    script.push_back('{event_of(OP_BULK_IN, EP_BULK_IN, SIZE_W'(64)), 1'b0, '0});
    ev = event_of(OP_SCSI_READY, 4'd0, '0);
    ev.transfer_len = 32'hFFFF_FFFF;
    script.push_back('{ev, 1'b0, '0});
    script.push_back('{event_of(OP_BULK_IN, EP_BULK_IN, SIZE_MAX), 1'b0, '0});
    ev = event_of(OP_SCSI_DONE, 4'd0, '0);
    ev.scsi_status = 8'hFF;
    script.push_back('{ev, 1'b0, '0});
    script.push_back('{event_of(OP_BULK_IN, EP_BULK_IN, CSW_BYTES - 1), 1'b1,
                       reply_of(PS_STALL, PH_STS)});
    script.push_back('{event_of(OP_BULK_IN, EP_BULK_IN, CSW_BYTES), 1'b0, '0});
    script.push_back('{wrapper_of(32'h0, 32'hFFFF_FFFF, 8'h7F, 8'd0, 1'b0), 1'b0, '0});
    script.push_back('{event_of(OP_BULK_OUT, EP_BULK_OUT, SIZE_MAX), 1'b0, '0});
    script.push_back('{event_of(OP_HOST_CANCEL, 4'd0, '0), 1'b0, '0});
    script.push_back('{event_of(OP_BUS_RESET, 4'd0, '0), 1'b1, reply_of(PS_NONE, PH_CMD)});
    script.push_back('{event_of(OP_HOST_CANCEL, 4'd0, '0), 1'b1, reply_of(PS_NONE, PH_CMD)});
    ev = event_of(OP_CONTROL, 4'd0, '0);
    ev.request_code = REQ_MS_RESET;
    script.push_back('{ev, 1'b1, reply_of(PS_OK, PH_CMD)});
    script.push_back('{wrapper_of(32'h5A5A_A5A5, 32'd0, 8'h80, 8'd1, 1'b1), 1'b0, '0});
    script.push_back('{event_of(OP_BULK_IN, EP_BULK_IN, SIZE_W'(64)), 1'b0, '0});
    script.push_back('{event_of(OP_SCSI_DONE, 4'd0, '0), 1'b0, '0});

    foreach (script[i]) send_event(script[i].ev, script[i].typed, script[i].want);

    for (int s = 0; s < 4; s++) begin
      settle();
      case (s)
        0: write_lun(4'd15);
        1: write_lun(4'd0);
        2: write_lun(4'($urandom_range(1, 14)));
        default: write_lun(4'd7);
      endcase
      gaps_on = (s != 3);
      repeat (EVENTS_PER_LUN) begin
        if (gaps_on && $urandom_range(0, 59) == 0) settle();
        send_event(random_event(), 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("usb_bulk_only_storage_engine_test: clean");
    end else begin
      $display("usb_bulk_only_storage_engine_test: errors");
    end
    $finish;
  end

endmodule
